@@ rtl/core/tiny_register_machine_execute_unit_macros.svh @@
// Assertion macros shared by the execute unit.
`ifndef TINY_REGISTER_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define TINY_REGISTER_MACHINE_EXECUTE_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define TRM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is held.
`define TRM_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/trm_pkg.sv @@
// Types and constants shared by the execute unit and its submodules.
`default_nettype none

package trm_pkg;

  localparam int REG_AW      = 3;
  localparam int ADDR_W      = 6;
  localparam int NUM_REGS    = 5;
  localparam int ADDR_SPAN   = 64;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int RES_DATA_W  = 66;
  localparam logic [31:0] PC_RESET = 32'd1;

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_PRN = 3'd3,
    OP_JMP = 3'd4,
    OP_JPN = 3'd5,
    OP_HLT = 3'd6,
    OP_BAD = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_REG  = 2'd0,
    KIND_MEM  = 2'd1,
    KIND_IMM  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Declared from the top bit down, so mode sits in the lowest bits.
  typedef struct packed {
    logic signed [31:0] immediate;
    logic [ADDR_W-1:0]  second_addr;
    logic [REG_AW-1:0]  second_reg;
    kind_t              second_kind;
    logic [ADDR_W-1:0]  first_addr;
    logic [REG_AW-1:0]  first_reg;
    kind_t              first_kind;
    op_t                mode;
  } instr_t;

  localparam int INSTR_W = $bits(instr_t);

  typedef struct packed {
    logic        print_valid;
    logic        bad_opcode;
    logic        halted;
    logic [31:0] print_value;
    logic [31:0] next_pc;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/trm_store.sv @@
// Synchronous storage array with two read ports, one write port and forwarding.
`default_nettype none

module trm_store
  import trm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW_IN = 6,
  parameter int DW    = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW_IN-1:0] rd0_addr,
  input  wire logic [AW_IN-1:0] rd1_addr,
  output logic [DW-1:0]         rd0_data,
  output logic [DW-1:0]         rd1_data,
  input  wire logic             wr_en,
  input  wire logic [AW_IN-1:0] wr_addr,
  input  wire logic [DW-1:0]    wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [AW_IN:0] LIMIT = (AW_IN + 1)'(DEPTH);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    raw0_r, raw1_r, fwd_data_r;
  logic             ok0_r, ok1_r, fwd0_r, fwd1_r;

  logic          in0, in1, wr_ok, hit0, hit1;
  logic [IW-1:0] idx0, idx1, widx;

  assign in0   = {1'b0, rd0_addr} < LIMIT;
  assign in1   = {1'b0, rd1_addr} < LIMIT;
  assign idx0  = rd0_addr[IW-1:0];
  assign idx1  = rd1_addr[IW-1:0];
  assign widx  = wr_addr[IW-1:0];
  assign wr_ok = wr_en && ({1'b0, wr_addr} < LIMIT);
  // A write in the same cycle as the read wins over the stored word.
  assign hit0  = wr_ok && (wr_addr == rd0_addr);
  assign hit1  = wr_ok && (wr_addr == rd1_addr);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      raw0_r     <= mem_r[idx0];
      raw1_r     <= mem_r[idx1];
      fwd_data_r <= wr_data;
      fwd0_r     <= hit0;
      fwd1_r     <= hit1;
      ok0_r      <= in0 && (vld_r[idx0] || hit0);
      ok1_r      <= in1 && (vld_r[idx1] || hit1);
    end
    if (wr_ok) begin
      mem_r[widx] <= wr_data;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[widx] <= 1'b1;
    end
  end

  assign rd0_data = !ok0_r ? '0 : (fwd0_r ? fwd_data_r : raw0_r);
  assign rd1_data = !ok1_r ? '0 : (fwd1_r ? fwd_data_r : raw1_r);

endmodule

`default_nettype wire

@@ rtl/core/trm_exec.sv @@
// Instruction evaluation: operand selection, arithmetic, branch and write-back decisions.
`default_nettype none

module trm_exec
  import trm_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire instr_t            ins,
  input  wire logic [31:0]       pc,
  input  wire logic              halt,
  input  wire logic [DW-1:0]     rf_rd0,
  input  wire logic [DW-1:0]     rf_rd1,
  input  wire logic [DW-1:0]     dm_rd0,
  input  wire logic [DW-1:0]     dm_rd1,
  output logic                   rf_we,
  output logic [REG_AW-1:0]      rf_wa,
  output logic [DW-1:0]          rf_wd,
  output logic                   dm_we,
  output logic [ADDR_W-1:0]      dm_wa,
  output logic [DW-1:0]          dm_wd,
  output logic                   halt_nxt,
  output res_t                   res
);

  logic [DW-1:0] imm, v1, v2;
  logic          v1_zero;

  assign imm     = DW'(ins.immediate);
  assign v1_zero = (v1 == '0);

  always_comb begin
    unique case (ins.first_kind)
      KIND_REG:  v1 = rf_rd0;
      KIND_MEM:  v1 = dm_rd0;
      KIND_IMM:  v1 = imm;
      KIND_NONE: v1 = '0;
    endcase
    unique case (ins.second_kind)
      KIND_REG:  v2 = rf_rd1;
      KIND_MEM:  v2 = dm_rd1;
      KIND_IMM:  v2 = imm;
      KIND_NONE: v2 = '0;
    endcase
  end

  always_comb begin
    rf_we           = 1'b0;
    rf_wa           = ins.first_reg;
    rf_wd           = v1;
    dm_we           = 1'b0;
    dm_wa           = ins.second_addr;
    dm_wd           = v1;
    halt_nxt        = halt;
    res.next_pc     = pc + 32'd1;
    res.print_valid = 1'b0;
    res.print_value = '0;
    res.bad_opcode  = 1'b0;
    unique case (ins.mode)
      OP_MOV: begin
        if (ins.first_kind == KIND_REG) begin
          if (ins.second_kind == KIND_REG) begin
            // A move of a register onto itself changes nothing.
            rf_we = (ins.first_reg != ins.second_reg);
            rf_wa = ins.second_reg;
          end else if (ins.second_kind == KIND_MEM) begin
            dm_we = 1'b1;
          end else if (ins.second_kind == KIND_IMM) begin
            rf_we = 1'b1;
            rf_wd = imm;
          end
        end else if (ins.first_kind == KIND_MEM) begin
          if (ins.second_kind == KIND_REG) begin
            rf_we = 1'b1;
            rf_wa = ins.second_reg;
          end else if (ins.second_kind == KIND_MEM) begin
            dm_we = 1'b1;
          end else if (ins.second_kind == KIND_IMM) begin
            dm_we = 1'b1;
            dm_wa = ins.first_addr;
            dm_wd = imm;
          end
        end
      end
      OP_ADD: begin
        rf_we = (ins.first_kind == KIND_REG);
        rf_wd = v1 + v2;
      end
      OP_SUB: begin
        rf_we = (ins.first_kind == KIND_REG);
        rf_wd = v1 - v2;
      end
      OP_PRN: begin
        res.print_valid = 1'b1;
        res.print_value = 32'(v1);
      end
      OP_JMP: begin
        if (ins.second_kind == KIND_NONE || v1_zero) begin
          res.next_pc = 32'(ins.immediate);
        end
      end
      OP_JPN: begin
        if (v1_zero || v1[DW-1]) begin
          res.next_pc = 32'(ins.immediate);
        end
      end
      OP_HLT: begin
        halt_nxt = 1'b1;
      end
      OP_BAD: begin
        res.bad_opcode = 1'b1;
        res.next_pc    = pc;
      end
    endcase
    res.halted = halt_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/tiny_register_machine_execute_unit.sv @@
// Top level of the execute unit for the five-register machine.
//
//   Channel  Direction  Ports                          Contents
//   in_      input      in_tvalid/in_tready/in_tdata   one pre-decoded instruction
//   out_     output     out_tvalid/out_tready/         next PC, print value, status
//                       out_tdata/out_tuser
//
// Each instruction passes through a read stage (register file and data
// memory are read, with the data registered) and an execute stage,
// where write-back happens as the result moves into the output register.
// Sustained rate is one item per cycle while out_tready is high; out_tvalid
// rises once the item has moved from the execute registers into the output
// register. A write issued by the executing item is forwarded to the
// reads of the item accepted in the same cycle. Reset clears the pipeline,
// sets the program counter to one and marks every stored word as zero at
// once. When out_tready is low the output register holds, then the execute
// stage, and in_tready drops.
`default_nettype none

module tiny_register_machine_execute_unit
  import trm_pkg::*;
#(
  parameter int MEM_WORDS = 64,
  parameter int DATA_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] mode, [4:3] first_kind, [7:5] first_reg, [13:8] first_addr,
  // [15:14] second_kind, [18:16] second_reg, [24:19] second_addr,
  // [56:25] immediate, [63:57] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] next_pc, [63:32] print_value, [64] halted, [65] bad_opcode,
  // [71:66] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [0] print_valid
  output logic                        out_tuser
);

  `include "tiny_register_machine_execute_unit_macros.svh"

  // Only the first 64 words can be addressed by the six-bit address fields.
  localparam int MEM_DEPTH = (MEM_WORDS < ADDR_SPAN) ? MEM_WORDS : ADDR_SPAN;

  instr_t in_ins;
  logic   in_accept;

  // Execute stage: the instruction whose operands are now in the read registers.
  logic   e_vld_r;
  instr_t e_ins_r;
  logic   e_fire;

  // Architectural scalars.
  logic [31:0] pc_r;
  logic        halt_r;
  logic        halt_nxt;

  // Output register.
  logic out_vld_r;
  res_t out_res_r;
  res_t e_res;

  logic [DATA_BITS-1:0] rf_rd0, rf_rd1, dm_rd0, dm_rd1;
  logic                 rf_we_raw, dm_we_raw, rf_we, dm_we;
  logic [REG_AW-1:0]    rf_wa;
  logic [ADDR_W-1:0]    dm_wa;
  logic [DATA_BITS-1:0] rf_wd, dm_wd;

  assign in_ins    = instr_t'(in_tdata[INSTR_W-1:0]);
  assign e_fire    = e_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !e_vld_r || e_fire;
  assign in_accept = in_tvalid && in_tready;

  // State changes only when the executing item actually leaves the stage.
  assign rf_we = rf_we_raw && e_fire;
  assign dm_we = dm_we_raw && e_fire;

  trm_store #(
    .DEPTH (NUM_REGS),
    .AW_IN (REG_AW),
    .DW    (DATA_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd0_addr (in_ins.first_reg),
    .rd1_addr (in_ins.second_reg),
    .rd0_data (rf_rd0),
    .rd1_data (rf_rd1),
    .wr_en    (rf_we),
    .wr_addr  (rf_wa),
    .wr_data  (rf_wd)
  );

  trm_store #(
    .DEPTH (MEM_DEPTH),
    .AW_IN (ADDR_W),
    .DW    (DATA_BITS)
  ) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd0_addr (in_ins.first_addr),
    .rd1_addr (in_ins.second_addr),
    .rd0_data (dm_rd0),
    .rd1_data (dm_rd1),
    .wr_en    (dm_we),
    .wr_addr  (dm_wa),
    .wr_data  (dm_wd)
  );

  trm_exec #(
    .DW (DATA_BITS)
  ) u_exec (
    .ins      (e_ins_r),
    .pc       (pc_r),
    .halt     (halt_r),
    .rf_rd0   (rf_rd0),
    .rf_rd1   (rf_rd1),
    .dm_rd0   (dm_rd0),
    .dm_rd1   (dm_rd1),
    .rf_we    (rf_we_raw),
    .rf_wa    (rf_wa),
    .rf_wd    (rf_wd),
    .dm_we    (dm_we_raw),
    .dm_wa    (dm_wa),
    .dm_wd    (dm_wd),
    .halt_nxt (halt_nxt),
    .res      (e_res)
  );

  // Pipeline valids and architectural scalars.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= PC_RESET;
      halt_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        e_vld_r <= 1'b1;
      end else if (e_fire) begin
        e_vld_r <= 1'b0;
      end
      if (e_fire) begin
        out_vld_r <= 1'b1;
        pc_r      <= e_res.next_pc;
        halt_r    <= halt_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_ins_r <= in_ins;
    end
    if (e_fire) begin
      out_res_r <= e_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.print_valid;
  assign out_tdata  = {{(OUT_TDATA_W - RES_DATA_W){1'b0}},
                       out_res_r.bad_opcode, out_res_r.halted,
                       out_res_r.print_value, out_res_r.next_pc};

  // An invalid opcode leaves the program counter where it was.
  `TRM_ASSERT_RST(a_bad_holds_pc, e_fire && e_ins_r.mode == OP_BAD |=> pc_r == $past(pc_r), "program counter moved on an invalid opcode")
  // Once halted, the machine stays halted until reset.
  `TRM_ASSERT_RST(a_halt_sticky, halt_r |=> halt_r, "halt flag cleared without reset")
  // One instruction writes either a register or a memory word, never both.
  `TRM_ASSERT_ALL(a_single_write, !(rf_we && dm_we), "register and memory written together")
  // A stalled execute stage keeps its instruction.
  `TRM_ASSERT_RST(a_exec_holds, e_vld_r && !e_fire |=> e_vld_r && $stable(e_ins_r), "execute stage overwritten while stalled")

endmodule

`default_nettype wire
